>>> rtl/core/bdp_pkg.sv
package bdp_pkg;

  // table geometry
  localparam int unsigned ADDR_BITS   = 12;
  localparam int unsigned IN_ADDR_W   = 12;
  localparam int unsigned TABLE_DEPTH = 1 << ADDR_BITS;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [ADDR_BITS-1:0] slot_t;

  // register indexes (word address bit)
  localparam logic [0:0] REG_MODE    = 1'b0;
  localparam logic [0:0] REG_DEFAULT = 1'b1;

  // predictor mode codes
  localparam logic MODE_ONE_BIT = 1'b0;
  localparam logic MODE_TWO_BIT = 1'b1;

  // register reset values
  localparam logic MODE_RESET    = MODE_TWO_BIT;
  localparam logic DEFAULT_RESET = 1'b1;

  typedef struct packed {
    logic [IN_ADDR_W-1:0] branch_addr;
    logic                 actual_taken;
  } bdp_req_t;

  typedef struct packed {
    logic predicted_taken;
    logic was_known;
    logic mispredicted;
  } bdp_rsp_t;

  typedef struct packed {
    logic valid;
    logic direction;
    logic hyst;
  } entry_t;

  // write request from the update stage to the table
  typedef struct packed {
    logic   en;
    slot_t  addr;
    entry_t entry;
  } wr_t;

  // map a branch address onto a table slot (truncate or zero-extend)
  function automatic slot_t to_slot(logic [IN_ADDR_W-1:0] addr);
    logic [ADDR_BITS+IN_ADDR_W-1:0] wide;
    wide = {ADDR_BITS'(0), addr};
    return wide[ADDR_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/bdp_table.sv
module bdp_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  bdp_pkg::slot_t       rd_addr_i,
  input  bdp_pkg::wr_t         wr_i,
  output bdp_pkg::entry_t      rd_entry_o,
  output logic                 init_done_o
);

  bdp_pkg::entry_t mem [bdp_pkg::TABLE_DEPTH];

  logic [bdp_pkg::ADDR_BITS:0] clr_cnt_q, clr_cnt_d;
  logic                        init_done;
  logic                        we;
  bdp_pkg::slot_t              waddr;
  bdp_pkg::entry_t             wdata;
  bdp_pkg::entry_t             rdata_q;
  logic                        fwd_q, fwd_d;
  bdp_pkg::entry_t             fwd_entry_q;

  assign init_done = clr_cnt_q[bdp_pkg::ADDR_BITS];

  // clearing sweep after reset, one entry per cycle
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (!init_done) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  // write port: sweep or update
  always_comb begin
    if (!init_done) begin
      we    = 1'b1;
      waddr = clr_cnt_q[bdp_pkg::ADDR_BITS-1:0];
      wdata = '0;
    end else begin
      we    = wr_i.en;
      waddr = wr_i.addr;
      wdata = wr_i.entry;
    end
  end

  // read sees old data on a same-slot write, so forward the new entry
  assign fwd_d = rd_en_i && we && (waddr == rd_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      fwd_q     <= 1'b0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      if (rd_en_i) begin
        fwd_q <= fwd_d;
      end
    end
  end

  // memory array and forwarded data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rdata_q     <= mem[rd_addr_i];
      fwd_entry_q <= wdata;
    end
  end

  assign rd_entry_o  = fwd_q ? fwd_entry_q : rdata_q;
  assign init_done_o = init_done;

endmodule

>>> rtl/core/branch_direction_predictor.sv
// Branch direction predictor: each request carries a branch address and its
// resolved outcome; the block answers with the prediction made before the
// update, whether the address had an entry, and whether it mispredicted. One
// request is accepted per cycle while in_ready_o is high. Each request passes
// through the update stage and then the response register: the single table
// memory is read at acceptance, and the table update and the response are
// written when the update stage advances. A back-to-back request to the same
// slot gets the new entry through a forwarding register. A response that
// waits on out_ready_i stalls the input only once the update stage is also
// full. After reset the table valid bits are cleared by a sweep over all
// 2^ADDR_BITS entries (4096 at the default size) during which in_ready_o
// stays low; configuration writes are taken at any time but belong between
// requests, with no request in flight.
module branch_direction_predictor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bdp_pkg::bdp_req_t                 in_req_i,
  // response channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bdp_pkg::bdp_rsp_t                 out_rsp_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bdp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bdp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic mode_q, mode_d;
  logic dflt_q, dflt_d;

  logic            init_done;
  logic            in_acc;
  logic            s1_q, s1_d;
  logic            s1_adv;
  bdp_pkg::slot_t  s1_slot_q;
  logic            s1_outcome_q;
  bdp_pkg::entry_t cur;
  bdp_pkg::entry_t nxt;
  logic            pred;
  bdp_pkg::wr_t    tbl_wr;
  logic            out_valid_q, out_valid_d;
  bdp_pkg::bdp_rsp_t out_rsp_q;

  // configuration registers
  assign pready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    dflt_d = dflt_q;
    if (psel && penable && pwrite) begin
      case (paddr[2:2])
        bdp_pkg::REG_MODE:    mode_d = pwdata[0];
        bdp_pkg::REG_DEFAULT: dflt_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      bdp_pkg::REG_MODE:    prdata = {{(bdp_pkg::APB_DATA_W-1){1'b0}}, mode_q};
      bdp_pkg::REG_DEFAULT: prdata = {{(bdp_pkg::APB_DATA_W-1){1'b0}}, dflt_q};
      default:              prdata = '0;
    endcase
  end

  // handshake and pipeline control
  assign s1_adv     = s1_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = init_done && (!s1_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_d       = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // table memory
  bdp_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_i   (bdp_pkg::to_slot(in_req_i.branch_addr)),
    .wr_i        (tbl_wr),
    .rd_entry_o  (cur),
    .init_done_o (init_done)
  );

  // prediction and entry update
  assign pred = cur.valid ? cur.direction : dflt_q;

  always_comb begin
    nxt.valid     = 1'b1;
    nxt.direction = s1_outcome_q;
    nxt.hyst      = 1'b0;
    if (cur.valid) begin
      if (mode_q == bdp_pkg::MODE_ONE_BIT) begin
        nxt.hyst = cur.hyst;
      end else if (pred != s1_outcome_q) begin
        // strong mispredict only drops hysteresis; weak one flips direction
        nxt.direction = cur.hyst ? cur.direction : s1_outcome_q;
        nxt.hyst      = 1'b0;
      end else begin
        nxt.direction = cur.direction;
        nxt.hyst      = 1'b1;
      end
    end
  end

  assign tbl_wr.en    = s1_adv;
  assign tbl_wr.addr  = s1_slot_q;
  assign tbl_wr.entry = nxt;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= bdp_pkg::MODE_RESET;
      dflt_q      <= bdp_pkg::DEFAULT_RESET;
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      dflt_q      <= dflt_d;
      s1_q        <= s1_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q    <= bdp_pkg::to_slot(in_req_i.branch_addr);
      s1_outcome_q <= in_req_i.actual_taken;
    end
    if (s1_adv) begin
      out_rsp_q.predicted_taken <= pred;
      out_rsp_q.was_known       <= cur.valid;
      out_rsp_q.mispredicted    <= pred ^ s1_outcome_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // no request taken while the table sweep runs
  a_no_acc_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> init_done)
    else $error("request accepted during table clear");

  // a new request can only enter when the update stage drains
  a_acc_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_q) |-> s1_adv)
    else $error("update stage overwritten");

  // a stalled update stage keeps its request
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q && !s1_adv) |=> (s1_q && $stable(s1_slot_q) && $stable(s1_outcome_q)))
    else $error("stalled update stage lost its request");

  // each table update yields a response on the next cycle
  a_wr_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |=> out_valid_q)
    else $error("table update without response");

endmodule
